FILE: rtl/multiscale_gaussian_filter_bank_unit_defines.svh
// assertion macros for the multiscale gaussian filter bank checker
`ifndef MULTISCALE_GAUSSIAN_FILTER_BANK_UNIT_DEFINES_SVH
`define MULTISCALE_GAUSSIAN_FILTER_BANK_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define MGFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define MGFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mgfb_pkg.sv
// package: constants, tap rom and rounding for the gaussian filter bank
`timescale 1ns / 1ps

package mgfb_pkg;

  typedef longint unsigned u64_t;

  localparam int unsigned DefChannels     = 32;
  localparam int unsigned DefHistoryDepth = 128;
  localparam int unsigned DefScales       = 8;

  localparam int unsigned OutScales = 8;
  localparam int unsigned MaxLen    = 1 << (OutScales - 1);
  localparam int unsigned TapCount  = (1 << OutScales) - 1;
  localparam int unsigned TapIdxW   = $clog2(TapCount);
  localparam int unsigned ScW       = $clog2(OutScales);
  localparam int unsigned JW        = OutScales - 1;
  localparam int unsigned SeenW     = 8;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned CfgW     = 6;
  localparam int unsigned TapW     = 16;
  localparam int unsigned ProdW    = SampleW + TapW + 1;
  localparam int unsigned AccW     = 40;
  localparam int unsigned OutDataW = OutScales * SampleW;

  localparam logic [CfgW-1:0] ActiveReset = CfgW'(28);

  typedef logic [TapCount-1:0][TapW-1:0] tap_rom_t;

  // per-tap control that travels down the mac pipeline
  typedef struct packed {
    logic           first;
    logic           last;
    logic           use_first;
    logic [ScW-1:0] scale;
  } tap_ctl_t;

  // restoring division, only evaluated while the tap rom is elaborated
  function automatic u64_t div_u64(input u64_t num, input u64_t den);
    u64_t quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // gaussian taps: exp(-t) in q30 by a 40-term series, normalized to q16
  function automatic tap_rom_t build_taps();
    tap_rom_t rom;
    u64_t     gw [MaxLen];
    u64_t     m, m2, jj, d, t, term, total, tap;
    longint   sum;
    int unsigned len, base;
    rom = '0;
    rom[0] = 16'hFFFF;
    rom[1] = 16'd32768;
    rom[2] = 16'd32768;
    rom[3] = 16'd11796;
    rom[4] = 16'd20972;
    rom[5] = 16'd20972;
    rom[6] = 16'd11796;
    for (int s = 3; s < OutScales; s++) begin
      len   = 32'd1 << s;
      base  = len - 1;
      m     = u64_t'(len - 1);
      m2    = m * m;
      total = 0;
      for (int j = 0; j < len; j++) begin
        jj = u64_t'(2 * j);
        d  = (jj > m) ? (jj - m) : (m - jj);
        t  = div_u64(u64_t'(204800) * d * d + (m2 >> 1), m2);
        term = u64_t'(1) << 30;
        sum  = longint'(1) << 30;
        for (int n = 1; n <= 40; n++) begin
          term = div_u64((term * t) >> 16, u64_t'(n));
          if ((n & 1) != 0) sum = sum - longint'(term);
          else              sum = sum + longint'(term);
        end
        gw[j] = (sum < 0) ? u64_t'(0) : u64_t'(sum);
        total = total + gw[j];
      end
      if (total == 0) total = 1;
      for (int j = 0; j < len; j++) begin
        tap = div_u64(gw[j] * 65536 + (total >> 1), total);
        rom[base + j] = (tap > 65535) ? 16'hFFFF : 16'(tap);
      end
    end
    return rom;
  endfunction

  localparam tap_rom_t TapRom = build_taps();

  // round half up by 16 bits and saturate to 16 bits
  function automatic logic [SampleW-1:0] round_sat(input logic signed [AccW-1:0] acc);
    logic        [AccW:0]    biased;
    logic signed [AccW-16:0] r;
    biased = {acc[AccW-1], acc} + (AccW + 1)'(32768);
    r      = biased[AccW:16];
    if (r > 32767) begin
      return 16'h7FFF;
    end else if (r < -32768) begin
      return 16'h8000;
    end else begin
      return r[SampleW-1:0];
    end
  endfunction

endpackage

FILE: rtl/multiscale_gaussian_filter_bank_unit.sv
// top level: per-channel sample history and a shared mac for the gaussian filter bank
//
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata = sample, tuser = channel
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata = scale_0..scale_7, tuser = out_channel
// cfg       | in  | cfg_we_i                     | cfg_wdata_i = active_channels
//
// one active sample passes through accept, tap steps for scales 1 up to min(SCALES,8)-1 on the
// single multiply-accumulate unit, a pipeline drain and a hand-off to the output register.
// a sample for an inactive channel is taken without starting the mac.
// reset is asynchronous, active low; history memory is not cleared, the first-sample
// substitution covers unwritten slots. the finished result waits in an output
// register, so the next sample is taken while m_axis is stalled.
`timescale 1ns / 1ps

module multiscale_gaussian_filter_bank_unit
  import mgfb_pkg::*;
#(
  parameter int unsigned CHANNELS      = DefChannels,
  parameter int unsigned HISTORY_DEPTH = DefHistoryDepth,
  parameter int unsigned SCALES        = DefScales
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,    // active_channels
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SampleW-1:0]  s_axis_tdata,   // [15:0] sample
  input  logic [ChanW-1:0]    s_axis_tuser,   // [4:0] channel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // scale_0 [15:0] up to scale_7 [127:112]
  output logic [ChanW-1:0]    m_axis_tuser    // [4:0] out_channel
);

  localparam int unsigned ChIdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned RpW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned MemDepth = CHANNELS * HISTORY_DEPTH;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned NumCalc  = (SCALES < OutScales) ? SCALES : OutScales;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRun    = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CfgW-1:0] active_q;

  logic [RpW-1:0]     wp_arr_q    [CHANNELS];
  logic [SeenW-1:0]   seen_arr_q  [CHANNELS];
  logic [SampleW-1:0] first_arr_q [CHANNELS];
  logic [SampleW-1:0] mem         [MemDepth];

  logic [ChanW-1:0]   c_q;
  logic [AddrW-1:0]   base_q;
  logic [RpW-1:0]     wp_q;
  logic [SeenW-1:0]   seen_q;
  logic [SampleW-1:0] first_q;

  logic [ScW-1:0] s_q, s_d;
  logic [JW-1:0]  j_q, j_d;
  logic [RpW-1:0] rp_q, rp_d;

  logic               p1_v_q, p2_v_q, p3_v_q;
  tap_ctl_t           p1_ctl_q, p2_ctl_q;
  logic [ScW-1:0]     p3_sc_q;
  logic [TapW-1:0]    p1_tap_q;
  logic [SampleW-1:0] rdata_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;

  logic [SampleW-1:0]  res_q [OutScales];
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [ChanW-1:0]    out_chan_q;

  logic               accept, chan_ok, go, issue, last_tap, pipe_empty, out_load;
  logic [ChIdxW-1:0]  chan_idx;
  logic [RpW-1:0]     cur_wp, next_wp, rp_prev;
  logic [SeenW-1:0]   cur_seen, new_seen;
  logic [AddrW-1:0]   chan_base, wr_addr, rd_addr;
  logic [TapIdxW-1:0] len_m1, tap_idx;
  tap_ctl_t           issue_ctl;
  logic signed [SampleW-1:0] op_s;
  logic signed [TapW:0]      tap_s;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign chan_ok       = ({1'b0, s_axis_tuser} < active_q) && (32'(s_axis_tuser) < CHANNELS);
  assign go            = accept && chan_ok;
  assign chan_idx      = ChIdxW'(s_axis_tuser);

  assign cur_wp    = wp_arr_q[chan_idx];
  assign cur_seen  = seen_arr_q[chan_idx];
  assign next_wp   = (cur_wp == RpW'(HISTORY_DEPTH - 1)) ? '0 : cur_wp + RpW'(1);
  assign new_seen  = (cur_seen == '1) ? cur_seen : cur_seen + SeenW'(1);
  assign chan_base = AddrW'(chan_idx) * AddrW'(HISTORY_DEPTH);
  assign wr_addr   = chan_base + AddrW'(cur_wp);
  assign rd_addr   = base_q + AddrW'(rp_q);

  // ring walks backwards from the newest slot
  assign rp_prev = (rp_q == '0) ? RpW'(HISTORY_DEPTH - 1) : rp_q - RpW'(1);

  assign issue    = (state_q == StRun);
  assign len_m1   = (TapIdxW'(1) << s_q) - TapIdxW'(1);
  assign last_tap = (TapIdxW'(j_q) == len_m1);
  assign tap_idx  = len_m1 + TapIdxW'(j_q);

  assign issue_ctl.first     = (j_q == '0);
  assign issue_ctl.last      = last_tap;
  assign issue_ctl.use_first = ({1'b0, j_q} >= seen_q);
  assign issue_ctl.scale     = s_q;

  assign pipe_empty = !p1_v_q && !p2_v_q && !p3_v_q;
  assign out_load   = (state_q == StFinish) && (!out_valid_q || m_axis_tready);

  assign op_s  = p1_ctl_q.use_first ? first_q : rdata_q;
  assign tap_s = {1'b0, p1_tap_q};

  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    j_d     = j_q;
    rp_d    = rp_q;
    unique case (state_q)
      StIdle: begin
        if (go) begin
          s_d     = ScW'(1);
          j_d     = '0;
          rp_d    = cur_wp;
          state_d = (NumCalc > 1) ? StRun : StDrain;
        end
      end
      StRun: begin
        if (last_tap) begin
          if (s_q == ScW'(NumCalc - 1)) begin
            state_d = StDrain;
          end else begin
            s_d  = s_q + ScW'(1);
            j_d  = '0;
            rp_d = wp_q;
          end
        end else begin
          j_d  = j_q + JW'(1);
          rp_d = rp_prev;
        end
      end
      StDrain: begin
        if (pipe_empty) state_d = StFinish;
      end
      StFinish: begin
        if (out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    for (int k = 0; k < OutScales; k++) begin
      out_data_d[k*SampleW +: SampleW] = (k < NumCalc) ? res_q[k] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= ActiveReset;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      s_q         <= '0;
      j_q         <= '0;
      rp_q        <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_arr_q[i]   <= '0;
        seen_arr_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      j_q     <= j_d;
      rp_q    <= rp_d;
      if (cfg_we_i) active_q <= cfg_wdata_i;
      p1_v_q <= issue;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q && p2_ctl_q.last;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (go) begin
        wp_arr_q[chan_idx]   <= next_wp;
        seen_arr_q[chan_idx] <= new_seen;
      end
    end
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (go) mem[wr_addr] <= s_axis_tdata;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      if (cur_seen == '0) first_arr_q[chan_idx] <= s_axis_tdata;
      c_q      <= s_axis_tuser;
      base_q   <= chan_base;
      wp_q     <= cur_wp;
      seen_q   <= new_seen;
      first_q  <= (cur_seen == '0) ? s_axis_tdata : first_arr_q[chan_idx];
      res_q[0] <= s_axis_tdata;
    end
    p1_ctl_q <= issue_ctl;
    p1_tap_q <= TapRom[tap_idx];
    p2_ctl_q <= p1_ctl_q;
    prod_q   <= op_s * tap_s;
    if (p2_v_q) begin
      acc_q <= (p2_ctl_q.first ? '0 : acc_q)
             + {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
    end
    p3_sc_q <= p2_ctl_q.scale;
    if (p3_v_q) res_q[p3_sc_q] <= round_sat(acc_q);
    if (out_load) begin
      out_data_q <= out_data_d;
      out_chan_q <= c_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_chan_q;

endmodule

FILE: rtl/mgfb_checker.sv
// port-level checker for the gaussian filter bank, bound to the top level
`timescale 1ns / 1ps
`include "multiscale_gaussian_filter_bank_unit_defines.svh"

module mgfb_checker
  import mgfb_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [ChanW-1:0]    m_axis_tuser
);

  // a stalled result stays offered
  `MGFB_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `MGFB_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result payload changed while stalled")

  // a new result only appears as the block leaves its busy phase
  `MGFB_ASSERT_IMP(a_out_after_busy, $rose(m_axis_tvalid), !$past(s_axis_tready) && s_axis_tready, "result appeared outside the hand-off")

  // an accepted sample never yields its result in the very next cycle
  `MGFB_ASSERT_NXT(a_no_instant_out, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result right after input transaction")

endmodule

bind multiscale_gaussian_filter_bank_unit mgfb_checker u_mgfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/mgfb_filter_checker.sv
// checker for the gaussian filter bank: watches both streams, predicts each result, compares
`timescale 1ns / 1ps

module mgfb_filter_checker
  import mgfb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [SampleW-1:0]  s_axis_tdata,
  input  logic [ChanW-1:0]    s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic [ChanW-1:0]    m_axis_tuser,
  output int unsigned         mismatch_cnt_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);

  localparam int unsigned NumChan   = DefChannels;
  localparam int unsigned HistDepth = DefHistoryDepth;
  localparam int unsigned NumScales = DefScales;
  localparam int unsigned MaxPrint  = 40;

  typedef struct packed {
    logic [ChanW-1:0]                    chan;
    logic [OutScales-1:0][SampleW-1:0]   scale;
  } filter_out_t;

  // predictor state
  logic [SampleW-1:0] ring      [NumChan][HistDepth];
  int unsigned        wr_pos    [NumChan];
  int unsigned        seen_cnt  [NumChan];
  logic [SampleW-1:0] first_smp [NumChan];
  logic [CfgW-1:0]    active_cfg;
  logic [TapW-1:0]    gauss_taps [TapCount];

  filter_out_t filtered_q [$];

  // exp(-t) in q30 by a 40-term series, t = 3.125 * d2 / m2 in q16
  function automatic longint unsigned exp_neg_q30(longint unsigned d2, longint unsigned m2);
    longint unsigned t, term;
    longint          acc;
    t    = (64'd204800 * d2 + m2 / 2) / m2;
    term = 64'd1 << 30;
    acc  = 64'sd1 << 30;
    for (int n = 1; n <= 40; n++) begin
      term = ((term * t) >> 16) / longint'(n);
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  function automatic longint unsigned tap_dist_sq(int unsigned j, int unsigned m);
    longint unsigned d;
    d = (2 * j > m) ? longint'(2 * j - m) : longint'(m - 2 * j);
    return d * d;
  endfunction

  initial begin
    longint unsigned total, wgt, tap, m, m2;
    int unsigned len, base;
    gauss_taps[0] = 16'hFFFF;
    gauss_taps[1] = 16'd32768;
    gauss_taps[2] = 16'd32768;
    gauss_taps[3] = 16'd11796;
    gauss_taps[4] = 16'd20972;
    gauss_taps[5] = 16'd20972;
    gauss_taps[6] = 16'd11796;
    for (int s = 3; s < OutScales; s++) begin
      len   = 1 << s;
      base  = len - 1;
      m     = 64'(len - 1);
      m2    = m * m;
      total = 0;
      for (int j = 0; j < len; j++) total += exp_neg_q30(tap_dist_sq(j, len - 1), m2);
      if (total == 0) total = 1;
      for (int j = 0; j < len; j++) begin
        wgt = exp_neg_q30(tap_dist_sq(j, len - 1), m2);
        tap = (wgt * 65536 + total / 2) / total;
        gauss_taps[base + j] = (tap > 65535) ? 16'hFFFF : tap[15:0];
      end
    end
  end

  function automatic logic [SampleW-1:0] round_half_sat(longint acc);
    longint r;
    r = (acc + 32768) >>> 16;
    if (r > 32767)  return 16'h7FFF;
    if (r < -32768) return 16'h8000;
    return r[15:0];
  endfunction

  // takes one active sample into the channel history and returns the eight filter outputs
  function automatic filter_out_t filter_sample(int unsigned ch, logic [SampleW-1:0] x);
    filter_out_t     res;
    int unsigned     wp, seen, len, base, slot;
    longint          acc;
    logic [SampleW-1:0] v;
    if (seen_cnt[ch] == 0) first_smp[ch] = x;
    wp = wr_pos[ch] % HistDepth;
    ring[ch][wp] = x;
    if (seen_cnt[ch] < 255) seen_cnt[ch]++;
    seen = seen_cnt[ch];
    res.chan     = ch[ChanW-1:0];
    res.scale    = '0;
    res.scale[0] = x;
    for (int s = 1; s < NumScales && s < OutScales; s++) begin
      len  = 1 << s;
      base = len - 1;
      acc  = 0;
      for (int j = 0; j < len; j++) begin
        if (j < seen) begin
          slot = (wp + HistDepth - (j % HistDepth)) % HistDepth;
          v    = ring[ch][slot];
        end else begin
          // reaching back before the first sample of the channel
          v = first_smp[ch];
        end
        acc += longint'($signed(v)) * longint'(gauss_taps[base + j]);
      end
      res.scale[s] = round_half_sat(acc);
    end
    wr_pos[ch] = (wp + 1) % HistDepth;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_cnt_o < MaxPrint)
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    mismatch_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filter_out_t want, got;
    int unsigned lim;
    if (!rst_ni) begin
      filtered_q.delete();
      for (int c = 0; c < NumChan; c++) begin
        wr_pos[c]   = 0;
        seen_cnt[c] = 0;
      end
      active_cfg     = ActiveReset;
      mismatch_cnt_o = 0;
      checked_o      = 0;
      pending_o     <= 0;
    end else begin
      // results first: a result at this edge comes from an earlier transaction
      if (m_axis_tvalid && m_axis_tready) begin
        got.chan  = m_axis_tuser;
        got.scale = m_axis_tdata;
        checked_o++;
        if (filtered_q.size() == 0) begin
          report_mismatch("result with nothing expected, channel", got.chan, 0);
        end else begin
          want = filtered_q.pop_front();
          if (got.chan !== want.chan) report_mismatch("out_channel", got.chan, want.chan);
          for (int k = 0; k < OutScales; k++) begin
            if (got.scale[k] !== want.scale[k])
              report_mismatch($sformatf("channel %0d scale_%0d", want.chan, k),
                              got.scale[k], want.scale[k]);
          end
        end
      end
      // a sample at this edge still sees the old channel count
      lim = (active_cfg > NumChan) ? NumChan : active_cfg;
      if (s_axis_tvalid && s_axis_tready && s_axis_tuser < lim)
        filtered_q = {filtered_q, filter_sample(s_axis_tuser, s_axis_tdata)};
      if (cfg_we_i) active_cfg = cfg_wdata_i;
      pending_o <= filtered_q.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// testbench top for the gaussian filter bank: stimulus, idling, verdict
`timescale 1ns / 1ps

module tb_top
  import mgfb_pkg::*;
();

  localparam int unsigned Limit      = 1500000;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned DrainWait  = 300;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata  = '0;
  logic [ChanW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [ChanW-1:0]    m_axis_tuser;

  int unsigned mismatch_cnt, pending, checked;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned hold_cnt      = 0;
  logic        hold_armed    = 1'b0;
  logic        hold_done     = 1'b0;
  int unsigned sent_cnt      = 0;
  int unsigned ignored_cnt   = 0;
  int unsigned cfg_writes    = 0;
  logic [CfgW-1:0] cur_cfg   = ActiveReset;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  multiscale_gaussian_filter_bank_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  mgfb_filter_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= Limit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off once armed
  always @(posedge clk_i) begin
    if (hold_armed && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
      if (hold_cnt == HoldCycles - 1) hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int unsigned live_channels(logic [CfgW-1:0] cfg);
    return (cfg > DefChannels) ? DefChannels : cfg;
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  stall_pct <= 0;  end
      IDLE_SEND: begin send_idle_pct = 62; stall_pct <= 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct <= 62; end
      default:   begin send_idle_pct = 35; stall_pct <= 35; end
    endcase
  endtask

  task automatic send_sample(input logic [ChanW-1:0] ch, input logic [SampleW-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
    if (ch >= live_channels(cur_cfg)) ignored_cnt++;
  endtask

  // called right after a transaction; valid drops for the next edge
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_active(input logic [CfgW-1:0] val);
    wait_results();
    // an ignored sample may still be in flight
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cfg = val;
    cfg_writes++;
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 4) return SampleW'($urandom);
    if (kind < 6) begin
      case ($urandom_range(3))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return SampleW'(int'($urandom_range(1024)) - 512);
  endfunction

  function automatic logic [ChanW-1:0] pick_channel();
    int unsigned lim;
    lim = live_channels(cur_cfg);
    if (lim != 0 && $urandom_range(99) < 88) return ChanW'($urandom_range(lim - 1));
    return ChanW'($urandom_range(DefChannels - 1));
  endfunction

  // n counts samples on live channels; with every channel off it counts all
  task automatic run_phase(input logic [CfgW-1:0] cfg, input idle_mode_e mode,
                           input int unsigned n, input logic long_hold,
                           input logic mid_pause);
    int unsigned done_cnt;
    logic [ChanW-1:0] ch;
    write_active(cfg);
    set_idling(mode);
    if (long_hold) hold_armed <= 1'b1;
    done_cnt = 0;
    while (done_cnt < n) begin
      ch = pick_channel();
      send_sample(ch, pick_sample());
      if (ch < live_channels(cur_cfg) || live_channels(cur_cfg) == 0) done_cnt++;
      if (mid_pause && done_cnt == n / 2) wait_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, priming from the first sample, ignored channels at reset config
    set_idling(IDLE_NONE);
    send_sample(5'd0,  16'h7FFF);
    send_sample(5'd0,  16'h7FFF);
    send_sample(5'd1,  16'h8000);
    send_sample(5'd1,  16'h8000);
    send_sample(5'd27, 16'h0000);
    send_sample(5'd28, 16'h1234);
    send_sample(5'd31, 16'hFFFF);
    send_sample(5'd2,  16'h7FFF);
    send_sample(5'd2,  16'h8000);
    send_sample(5'd2,  16'h7FFF);
    send_sample(5'd2,  16'h8000);
    send_sample(5'd3,  16'h0001);
    send_sample(5'd3,  16'hFFFF);
    send_sample(5'd3,  16'h00FF);
    send_sample(5'd3,  16'hFF00);
    send_sample(5'd3,  16'h5555);
    send_sample(5'd3,  16'hAAAA);
    send_sample(5'd26, 16'h0100);
    send_sample(5'd0,  16'h8000);
    send_sample(5'd27, 16'h7FFF);

    run_phase(6'd32, IDLE_NONE, 200, 1'b0, 1'b0);
    // one channel only: its history wraps and the sample count saturates
    run_phase(6'd1,  IDLE_SEND, 300, 1'b0, 1'b0);
    run_phase(6'd63, IDLE_RECV, 200, 1'b1, 1'b0);
    run_phase(6'd0,  IDLE_BOTH, 40,  1'b0, 1'b0);
    run_phase(6'd17, IDLE_BOTH, 200, 1'b0, 1'b0);
    run_phase(ActiveReset, IDLE_NONE, 100, 1'b0, 1'b1);

    wait_results();
    repeat (DrainWait) @(posedge clk_i);

    $display("summary: %0d samples sent (%0d on inactive channels), %0d results checked",
             sent_cnt, ignored_cnt, checked);
    $display("summary: %0d active-channel settings, idle and stall mixes, one long hold-off",
             cfg_writes);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_cnt, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
